### rtl/core/pbxs_pkg.sv
// Package: shared constants, types and request codes of the Bragg sampler.
package pbxs_pkg;
	localparam int MaxPlanes = 1024;
	localparam int IdxW = 10;
	localparam int CntW = 11;
	localparam int RandBits = 24;
	localparam int DivW = 64;
	localparam logic [31:0] MU_ONE = 32'h4000_0000;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_CHK0,
		ST_S1RD,
		ST_S1CMP,
		ST_TOPRD,
		ST_TOP,
		ST_XSDIV,
		ST_S2RD,
		ST_S2CMP,
		ST_SELRD,
		ST_MUDIV,
		ST_OUT
	} state_t;

	localparam logic [1:0] ADDR_PLANE_COUNT = 2'd0;
endpackage

### rtl/core/powder_bragg_xs_and_angle_sampler_unit.sv
// Top level: powder Bragg cross section and scatter cosine sampler.
// A load request (tuser=0) writes one edge/cumulative table entry, and loads can follow
// back to back. A query request (tuser=1) runs two binary searches of p1 and p2 probes
// (at most 10 each at 1024 planes), where each probe is a registered RAM read and then one
// compare, and two 64-bit divisions by the energy in one shared bit-serial divider. A
// query that has zero energy, falls below the first edge, or finds no planes returns below
// threshold without the searches or divisions. The block takes no request while a query
// is at work or a result waits; the result waits in an output register and the next
// request is accepted in the cycle after it is taken. Tables are undefined until loaded;
// plane_count (APB address 0) above 1024 acts as 1024.
module powder_bragg_xs_and_angle_sampler_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_index[9:0], entry_edge_energy[41:10], entry_cumulative[73:42],
	// query_energy[105:74], random_fraction[129:106], zero fill to 136
	input  logic [135:0] s_tdata,
	// req_type
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// below_threshold[0], cross_section[32:1], scatter_mu[64:33], chosen_plane[74:65]
	output logic [79:0]  m_tdata
);
	import pbxs_pkg::*;

	state_t state_q, state_d;
	logic [CntW-1:0] pc_q;
	logic [CntW-1:0] n;
	logic [CntW-1:0] lo_q, hi_q, lo_d, hi_d, mid;
	logic [31:0] energy_q, xs_q;
	logic [RandBits-1:0] frac_q;
	logic [55:0] target_q;
	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	logic [31:0] edge_rd, cum_rd;
	logic div_start, div_done;
	logic [63:0] div_num, div_quo;
	logic in_fire, out_fire;
	logic [IdxW-1:0] sel_q;
	logic res_below;
	logic [31:0] res_xs, res_mu;
	logic res_load;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PLANE_COUNT) ? {21'd0, pc_q} : 32'd0;
	assign n = (pc_q > CntW'(MaxPlanes)) ? CntW'(MaxPlanes) : pc_q;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_PLANE_COUNT) begin
			pc_q <= pwdata[CntW-1:0];
		end
	end

	pbxs_ram #(.Width(32), .Depth(MaxPlanes)) u_edge (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s_tdata[41:10]), .rdata(edge_rd));
	pbxs_ram #(.Width(32), .Depth(MaxPlanes)) u_cum (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s_tdata[73:42]), .rdata(cum_rd));

	pbxs_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(energy_q), .done(div_done), .quotient(div_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_fire) m_tvalid <= 1'b0;
			if (res_load) m_tvalid <= 1'b1;
		end
	end

	// Search bounds and payload registers.
	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (in_fire) begin
			energy_q <= s_tdata[105:74];
			frac_q <= s_tdata[129:106];
		end
		if (state_q == ST_TOP) begin
			target_q <= 56'(frac_q) * 56'(cum_rd);
		end
		if (state_q == ST_XSDIV && div_done) begin
			xs_q <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
		end
		if (state_q == ST_SELRD) sel_q <= lo_q[IdxW-1:0];
		if (res_load) m_tdata <= {5'd0, (res_below ? {IdxW{1'b0}} : sel_q), res_mu,
			res_xs, res_below};
	end

	always_comb begin
		state_d = state_q;
		lo_d = lo_q;
		hi_d = hi_q;
		ram_we = 1'b0;
		ram_addr = mid[IdxW-1:0];
		div_start = 1'b0;
		div_num = {8'd0, cum_rd, 24'd0};
		res_load = 1'b0;
		res_below = 1'b0;
		res_xs = xs_q;
		res_mu = MU_ONE;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = s_tdata[IdxW-1:0];
				if (in_fire) begin
					if (req_t'(s_tuser) == REQ_LOAD) begin
						ram_we = 1'b1;
					end else begin
						ram_addr = '0;
						state_d = ST_CHK0;
					end
				end
			end
			ST_RD0: begin
				ram_addr = '0;
				state_d = ST_CHK0;
			end
			ST_CHK0: begin
				if (n == '0 || energy_q == 32'd0 || energy_q < edge_rd) begin
					res_load = 1'b1;
					res_below = 1'b1;
					res_xs = 32'd0;
					state_d = ST_IDLE;
				end else begin
					lo_d = CntW'(1);
					hi_d = n;
					state_d = ST_S1RD;
				end
			end
			ST_S1RD: begin
				if (lo_q < hi_q) state_d = ST_S1CMP;
				else begin
					ram_addr = IdxW'(lo_q - CntW'(1));
					state_d = ST_TOP;
				end
			end
			ST_S1CMP: begin
				if (energy_q < edge_rd) hi_d = mid;
				else lo_d = mid + CntW'(1);
				state_d = ST_S1RD;
			end
			ST_TOPRD: state_d = ST_TOP;
			ST_TOP: begin
				// Start the cross section divide straight from the top weight read.
				div_num = {8'd0, cum_rd, 24'd0};
				div_start = 1'b1;
				hi_d = lo_q - CntW'(1);
				lo_d = '0;
				state_d = ST_XSDIV;
			end
			ST_XSDIV: begin
				if (div_done) state_d = ST_S2RD;
			end
			ST_S2RD: begin
				if (lo_q < hi_q) state_d = ST_S2CMP;
				else begin
					ram_addr = lo_q[IdxW-1:0];
					state_d = ST_SELRD;
				end
			end
			ST_S2CMP: begin
				if ({cum_rd, 24'd0} < target_q) lo_d = mid + CntW'(1);
				else hi_d = mid;
				state_d = ST_S2RD;
			end
			ST_SELRD: begin
				div_num = {1'b0, edge_rd, 31'd0};
				div_start = 1'b1;
				state_d = ST_MUDIV;
			end
			ST_MUDIV: begin
				if (div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				res_mu = (div_quo > 64'h8000_0000) ? 32'hC000_0000 :
					MU_ONE - div_quo[31:0];
				res_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("accepted while busy");
	ap_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !m_tvalid || m_tready) else $error("result overwritten");
	ap_below_mu: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[64:33] == MU_ONE) else $error("below mu");
endmodule

### rtl/core/pbxs_ram.sv
// Generic single-port RAM with registered read.
module pbxs_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/pbxs_div.sv
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module pbxs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import pbxs_pkg::*;

	logic [32:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic        ge;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign ge = shifted >= {1'b0, divisor};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? shifted - {1'b0, divisor} : shifted;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done held");
	ap_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == 7'd0 || $past(start)) else $error("divider count stray");
endmodule
